/* hw/rtl/cube_vertex_transform_engine_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros shared by the cube vertex transform engine
// ---------------------------------------------------------------------------
`ifndef CUBE_VERTEX_TRANSFORM_ENGINE_DEFINES_SVH
`define CUBE_VERTEX_TRANSFORM_ENGINE_DEFINES_SVH

// same-cycle implication, clk and rst_n taken from the enclosing module
`define CVTE_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("cvte assertion failed");

// next-cycle implication
`define CVTE_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("cvte assertion failed");

`endif

/* hw/rtl/cvte_pkg.sv */
// ---------------------------------------------------------------------------
// cvte_pkg
// Types, constants and arithmetic helpers for the cube vertex transform engine.
// ---------------------------------------------------------------------------
package cvte_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int DW   = COORD_WIDTH + 1;    // vertex minus centroid
  localparam int PW   = DW + 17;            // difference times 17-bit factor
  localparam int SW   = COORD_WIDTH + 3;    // sum of eight coordinates
  localparam int WIDE = (COORD_WIDTH + 34 > 58) ? COORD_WIDTH + 34 : 58;
  localparam int NUM_VERT = 8;
  localparam int NUM_EDGE = 12;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  typedef enum logic [2:0] {
    KIND_BUILD = 3'd0,
    KIND_TRANS = 3'd1,
    KIND_SCALE = 3'd2,
    KIND_ROT_X = 3'd3,
    KIND_ROT_Y = 3'd4,
    KIND_ROT_Z = 3'd5,
    KIND_DRAW  = 3'd6
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_XLAT1,
    ST_XLAT2,
    ST_CENT,
    ST_PASS,
    ST_BUILD,
    ST_DRAW_RD,
    ST_DRAW_WR
  } state_t;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [23:0] distance;
    logic signed [15:0] cos_a;
    logic signed [15:0] sin_a;
    logic signed [15:0] cos_b;
    logic signed [15:0] sin_b;
    logic [15:0]        scale_x;
    logic [15:0]        scale_y;
    logic [15:0]        scale_z;
  } in_req_t;

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t start_z;
    coord_t end_x;
    coord_t end_y;
    coord_t end_z;
    logic   last_edge;
  } out_resp_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vert_t;

  // start index in bits 5..3, end index in bits 2..0
  localparam logic [5:0] EDGE_TABLE [NUM_EDGE] = '{
    6'o01, 6'o12, 6'o23, 6'o30, 6'o45, 6'o56,
    6'o67, 6'o74, 6'o04, 6'o15, 6'o26, 6'o37
  };

  localparam logic signed [WIDE-1:0] CMAX =
    {{(WIDE-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [WIDE-1:0] CMIN = ~CMAX;

  function automatic coord_t sat_coord(input logic signed [WIDE-1:0] v);
    if (v > CMAX) return CMAX[COORD_WIDTH-1:0];
    if (v < CMIN) return CMIN[COORD_WIDTH-1:0];
    return v[COORD_WIDTH-1:0];
  endfunction

  // round half up, then floor
  function automatic logic signed [WIDE-1:0] rnd_shr(input logic signed [WIDE-1:0] v,
                                                     input logic [4:0] sh);
    logic signed [WIDE-1:0] half;
    half = {{(WIDE-1){1'b0}}, 1'b1} << (sh - 5'd1);
    return (v + half) >>> sh;
  endfunction

  function automatic coord_t half_side(input logic [22:0] side);
    return sat_coord(WIDE'(signed'({1'b0, side[22:1]})));
  endfunction

  function automatic vert_t cube_corner(input logic [2:0] idx, input coord_t h);
    vert_t v;
    v.x = (idx[1:0] == 2'd1 || idx[1:0] == 2'd2) ? h : -h;
    v.y = idx[2] ? h : -h;
    v.z = (idx[1] == 1'b0) ? h : -h;
    return v;
  endfunction

  localparam logic [22:0] SIDE_RESET = 23'd15360;
  localparam coord_t RESET_HALF = half_side(SIDE_RESET);

endpackage

/* hw/rtl/cvte_vert_mem.sv */
// ---------------------------------------------------------------------------
// cvte_vert_mem
// Eight-entry vertex store, one write port and two registered read ports.
// An entry never written since reset reads as its reset cube corner.
// ---------------------------------------------------------------------------
module cvte_vert_mem (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [2:0]           wr_addr,
  input  cvte_pkg::vert_t      wr_data,
  input  logic                 rd_en,
  input  logic [2:0]           rd_addr_a,
  input  logic [2:0]           rd_addr_b,
  output cvte_pkg::vert_t      rd_data_a,
  output cvte_pkg::vert_t      rd_data_b
);

  cvte_pkg::vert_t mem [cvte_pkg::NUM_VERT];
  logic [cvte_pkg::NUM_VERT-1:0] valid_r;
  cvte_pkg::vert_t dat_a_r, dat_b_r;
  logic            vld_a_r, vld_b_r;
  logic [2:0]      adr_a_r, adr_b_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      dat_a_r <= mem[rd_addr_a];
      dat_b_r <= mem[rd_addr_b];
      adr_a_r <= rd_addr_a;
      adr_b_r <= rd_addr_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        vld_a_r <= valid_r[rd_addr_a];
        vld_b_r <= valid_r[rd_addr_b];
      end
    end
  end

  assign rd_data_a = vld_a_r ? dat_a_r : cvte_pkg::cube_corner(adr_a_r, cvte_pkg::RESET_HALF);
  assign rd_data_b = vld_b_r ? dat_b_r : cvte_pkg::cube_corner(adr_b_r, cvte_pkg::RESET_HALF);

endmodule

/* hw/rtl/cube_vertex_transform_engine.sv */
// ---------------------------------------------------------------------------
// cube_vertex_transform_engine
// Holds eight cube vertices and transforms or draws them, one request at a time.
// ---------------------------------------------------------------------------
//  channel  | handshake            | payload
//  in_      | in_valid / in_stall  | in_data  (kind, distance, angles, scales)
//  out_     | out_valid / out_stall| out_data (edge start/end, last_edge)
//  cfg_     | cfg_we               | cfg_wdata (side_length)
//
// Rebuild writes the eight corners from side_length; translate works out its offsets
// and then makes a transform pass; scale and rotate make a centroid pass and then a
// transform pass; draw reads and sends one edge at a time and is held by output stalls. An unused kind is dropped.
// Reset is synchronous; the vertex store reads as the default cube at once.
// in_stall is high while a request is at work; out_stall only holds a draw.
// ---------------------------------------------------------------------------
`include "cube_vertex_transform_engine_defines.svh"

module cube_vertex_transform_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cvte_pkg::in_req_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cvte_pkg::out_resp_t out_data,
  input  logic                cfg_we,
  input  logic [22:0]         cfg_wdata
);

  localparam int DW = cvte_pkg::DW;
  localparam int PW = cvte_pkg::PW;
  localparam int SW = cvte_pkg::SW;
  localparam int WIDE = cvte_pkg::WIDE;

  cvte_pkg::state_t state_r, state_nxt;
  logic [3:0]       cnt_r, cnt_nxt;
  cvte_pkg::in_req_t req_r;
  logic [22:0]      side_r;
  logic signed [SW-1:0] acc_x_r, acc_y_r, acc_z_r;
  logic signed [39:0] t1_r, t2_r, t3_r;
  logic signed [WIDE-1:0] dx_r, dy_r, dz_r;
  logic signed [55:0] xp, zp;

  logic            wr_en, rd_en;
  logic [2:0]      wr_addr, rd_addr_a, rd_addr_b;
  cvte_pkg::vert_t wr_data, rd_a, rd_b;

  logic            p1_v_r, p2_v_r, p3_v_r;
  logic [2:0]      p1_a_r, p2_a_r, p3_a_r;
  cvte_pkg::vert_t p2_vert_r, p3_vert_r;
  logic signed [DW-1:0] opa_nxt [4];
  logic signed [16:0]   opb_nxt [4];
  logic signed [DW-1:0] opa_r [4];
  logic signed [16:0]   opb_r [4];
  logic signed [PW-1:0] m_r [4];

  cvte_pkg::coord_t cx, cy, cz;
  logic signed [DW-1:0] ex, ey, ez;
  logic signed [WIDE-1:0] r0, r1, rs0, rs1, rs2;
  cvte_pkg::vert_t new_v;

  logic      out_valid_r, load;
  cvte_pkg::out_resp_t out_data_r;
  logic      accept;

  cvte_vert_mem u_mem (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  assign accept   = in_valid && (state_r == cvte_pkg::ST_IDLE);
  assign in_stall = (state_r != cvte_pkg::ST_IDLE);

  // centroid
  assign cx = cvte_pkg::coord_t'(acc_x_r >>> 3);
  assign cy = cvte_pkg::coord_t'(acc_y_r >>> 3);
  assign cz = cvte_pkg::coord_t'(acc_z_r >>> 3);

  assign ex = DW'(rd_a.x) - DW'(cx);
  assign ey = DW'(rd_a.y) - DW'(cy);
  assign ez = DW'(rd_a.z) - DW'(cz);

  always_comb begin
    logic signed [16:0] c17, s17;
    c17 = 17'(req_r.cos_a);
    s17 = 17'(req_r.sin_a);
    for (int k = 0; k < 4; k++) begin
      opa_nxt[k] = '0;
      opb_nxt[k] = '0;
    end
    case (cvte_pkg::kind_t'(req_r.kind))
      cvte_pkg::KIND_SCALE: begin
        opa_nxt[0] = ex; opb_nxt[0] = {1'b0, req_r.scale_x};
        opa_nxt[1] = ey; opb_nxt[1] = {1'b0, req_r.scale_y};
        opa_nxt[2] = ez; opb_nxt[2] = {1'b0, req_r.scale_z};
      end
      cvte_pkg::KIND_ROT_X: begin
        opa_nxt[0] = ey; opa_nxt[1] = ez; opa_nxt[2] = ey; opa_nxt[3] = ez;
        opb_nxt[0] = c17; opb_nxt[1] = s17; opb_nxt[2] = s17; opb_nxt[3] = c17;
      end
      cvte_pkg::KIND_ROT_Y: begin
        opa_nxt[0] = ez; opa_nxt[1] = ex; opa_nxt[2] = ez; opa_nxt[3] = ex;
        opb_nxt[0] = c17; opb_nxt[1] = s17; opb_nxt[2] = s17; opb_nxt[3] = c17;
      end
      cvte_pkg::KIND_ROT_Z: begin
        opa_nxt[0] = ex; opa_nxt[1] = ey; opa_nxt[2] = ex; opa_nxt[3] = ey;
        opb_nxt[0] = c17; opb_nxt[1] = s17; opb_nxt[2] = s17; opb_nxt[3] = c17;
      end
      default: begin
      end
    endcase
  end

  // write-back stage
  assign r0  = cvte_pkg::rnd_shr(WIDE'(m_r[0]) - WIDE'(m_r[1]), 5'd14);
  assign r1  = cvte_pkg::rnd_shr(WIDE'(m_r[2]) + WIDE'(m_r[3]), 5'd14);
  assign rs0 = cvte_pkg::rnd_shr(WIDE'(m_r[0]), 5'd12);
  assign rs1 = cvte_pkg::rnd_shr(WIDE'(m_r[1]), 5'd12);
  assign rs2 = cvte_pkg::rnd_shr(WIDE'(m_r[2]), 5'd12);

  always_comb begin
    new_v = p3_vert_r;
    case (cvte_pkg::kind_t'(req_r.kind))
      cvte_pkg::KIND_TRANS: begin
        new_v.x = cvte_pkg::sat_coord(WIDE'(p3_vert_r.x) + dx_r);
        new_v.y = cvte_pkg::sat_coord(WIDE'(p3_vert_r.y) + dy_r);
        new_v.z = cvte_pkg::sat_coord(WIDE'(p3_vert_r.z) + dz_r);
      end
      cvte_pkg::KIND_SCALE: begin
        new_v.x = cvte_pkg::sat_coord(WIDE'(cx) + rs0);
        new_v.y = cvte_pkg::sat_coord(WIDE'(cy) + rs1);
        new_v.z = cvte_pkg::sat_coord(WIDE'(cz) + rs2);
      end
      cvte_pkg::KIND_ROT_X: begin
        new_v.y = cvte_pkg::sat_coord(WIDE'(cy) + r0);
        new_v.z = cvte_pkg::sat_coord(WIDE'(cz) + r1);
      end
      cvte_pkg::KIND_ROT_Y: begin
        new_v.z = cvte_pkg::sat_coord(WIDE'(cz) + r0);
        new_v.x = cvte_pkg::sat_coord(WIDE'(cx) + r1);
      end
      cvte_pkg::KIND_ROT_Z: begin
        new_v.x = cvte_pkg::sat_coord(WIDE'(cx) + r0);
        new_v.y = cvte_pkg::sat_coord(WIDE'(cy) + r1);
      end
      default: begin
      end
    endcase
  end

  assign xp = t1_r * req_r.cos_b;
  assign zp = t2_r * req_r.cos_b;

  assign load = (state_r == cvte_pkg::ST_DRAW_WR) && (!out_valid_r || !out_stall);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rd_en     = 1'b0;
    rd_addr_a = cnt_r[2:0];
    rd_addr_b = cnt_r[2:0];
    wr_en     = 1'b0;
    wr_addr   = p3_a_r;
    wr_data   = new_v;
    case (state_r)
      cvte_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          case (cvte_pkg::kind_t'(in_data.kind))
            cvte_pkg::KIND_BUILD: state_nxt = cvte_pkg::ST_BUILD;
            cvte_pkg::KIND_TRANS: state_nxt = cvte_pkg::ST_XLAT1;
            cvte_pkg::KIND_SCALE,
            cvte_pkg::KIND_ROT_X,
            cvte_pkg::KIND_ROT_Y,
            cvte_pkg::KIND_ROT_Z: state_nxt = cvte_pkg::ST_CENT;
            cvte_pkg::KIND_DRAW:  state_nxt = cvte_pkg::ST_DRAW_RD;
            default:              state_nxt = cvte_pkg::ST_IDLE;
          endcase
        end
      end
      cvte_pkg::ST_XLAT1: state_nxt = cvte_pkg::ST_XLAT2;
      cvte_pkg::ST_XLAT2: state_nxt = cvte_pkg::ST_PASS;
      cvte_pkg::ST_CENT: begin
        rd_en   = !cnt_r[3];
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd8) begin
          cnt_nxt   = '0;
          state_nxt = cvte_pkg::ST_PASS;
        end
      end
      cvte_pkg::ST_PASS: begin
        rd_en   = !cnt_r[3];
        wr_en   = p3_v_r;
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd10) begin
          state_nxt = cvte_pkg::ST_IDLE;
        end
      end
      cvte_pkg::ST_BUILD: begin
        wr_en   = 1'b1;
        wr_addr = cnt_r[2:0];
        wr_data = cvte_pkg::cube_corner(cnt_r[2:0], cvte_pkg::half_side(side_r));
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd7) begin
          state_nxt = cvte_pkg::ST_IDLE;
        end
      end
      cvte_pkg::ST_DRAW_RD: begin
        rd_en     = 1'b1;
        rd_addr_a = cvte_pkg::EDGE_TABLE[cnt_r][5:3];
        rd_addr_b = cvte_pkg::EDGE_TABLE[cnt_r][2:0];
        state_nxt = cvte_pkg::ST_DRAW_WR;
      end
      cvte_pkg::ST_DRAW_WR: begin
        if (load) begin
          cnt_nxt   = cnt_r + 4'd1;
          state_nxt = (cnt_r == 4'(cvte_pkg::NUM_EDGE - 1)) ? cvte_pkg::ST_IDLE
                                                             : cvte_pkg::ST_DRAW_RD;
        end
      end
      default: state_nxt = cvte_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cvte_pkg::ST_IDLE;
      cnt_r       <= '0;
      side_r      <= cvte_pkg::SIDE_RESET;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      p3_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_we) begin
        side_r <= cfg_wdata;
      end
      p1_v_r <= rd_en && (state_r == cvte_pkg::ST_PASS);
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_data;
      acc_x_r <= '0;
      acc_y_r <= '0;
      acc_z_r <= '0;
    end else if (state_r == cvte_pkg::ST_CENT && cnt_r != 4'd0) begin
      acc_x_r <= acc_x_r + SW'(rd_a.x);
      acc_y_r <= acc_y_r + SW'(rd_a.y);
      acc_z_r <= acc_z_r + SW'(rd_a.z);
    end
    if (state_r == cvte_pkg::ST_XLAT1) begin
      t1_r <= req_r.distance * req_r.cos_a;
      t2_r <= req_r.distance * req_r.sin_a;
      t3_r <= req_r.distance * req_r.sin_b;
    end
    if (state_r == cvte_pkg::ST_XLAT2) begin
      dx_r <= cvte_pkg::rnd_shr(WIDE'(xp), 5'd28);
      dz_r <= cvte_pkg::rnd_shr(WIDE'(zp), 5'd28);
      dy_r <= cvte_pkg::rnd_shr(WIDE'(t3_r), 5'd14);
    end
    p1_a_r    <= rd_addr_a;
    p2_a_r    <= p1_a_r;
    p2_vert_r <= rd_a;
    p3_a_r    <= p2_a_r;
    p3_vert_r <= p2_vert_r;
    for (int k = 0; k < 4; k++) begin
      opa_r[k] <= opa_nxt[k];
      opb_r[k] <= opb_nxt[k];
      m_r[k]   <= opa_r[k] * opb_r[k];
    end
    if (load) begin
      out_data_r.start_x   <= rd_a.x;
      out_data_r.start_y   <= rd_a.y;
      out_data_r.start_z   <= rd_a.z;
      out_data_r.end_x     <= rd_b.x;
      out_data_r.end_y     <= rd_b.y;
      out_data_r.end_z     <= rd_b.z;
      out_data_r.last_edge <= (cnt_r == 4'(cvte_pkg::NUM_EDGE - 1));
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `CVTE_ASSERT_NOW(a_out_from_draw, $rose(out_valid_r),
                   $past(state_r) == cvte_pkg::ST_DRAW_WR)
  `CVTE_ASSERT_NOW(a_wr_states, wr_en,
                   state_r == cvte_pkg::ST_PASS || state_r == cvte_pkg::ST_BUILD)
  `CVTE_ASSERT_NEXT(a_last_flag, load && cnt_r == 4'(cvte_pkg::NUM_EDGE - 1),
                    out_data_r.last_edge && state_r == cvte_pkg::ST_IDLE)
  `CVTE_ASSERT_NOW(a_pass_write, p3_v_r,
                   state_r == cvte_pkg::ST_PASS && cnt_r >= 4'd3)

endmodule
